// File: sv/bsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types, mode codes and character constants of the backslash escape
// decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_HEX_HI = 2'd2;
    localparam logic [1:0] MODE_HEX_LO = 2'd3;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_N_UPPER   = 8'h4E;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;
    localparam logic [7:0] CTRL_MAX     = 8'd31;
    localparam logic [7:0] HEX_INVALID  = 8'hFF;

    // One result transfer on the output channel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_error;
        logic       run_last;
        logic       stream_end;
    } bsd_result_t;

    // Everything the decoder derives from one input byte.
    typedef struct packed {
        logic [1:0]  count;
        bsd_result_t res0;
        bsd_result_t res1;
        logic [1:0]  mode_next;
        logic [3:0]  nibble_next;
    } bsd_decode_t;

    function automatic logic [7:0] hex_value(input logic [7:0] ch);
        logic [7:0] v;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            v = ch - 8'h30;
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            v = ch - 8'h37;
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            v = ch - 8'h57;
        end else begin
            v = HEX_INVALID;
        end
        return v;
    endfunction

    function automatic logic [7:0] simple_escape(input logic [7:0] ch);
        logic [7:0] d;
        unique case (ch)
            8'h61:   d = 8'h07;
            8'h62:   d = 8'h08;
            8'h65:   d = 8'h1B;
            8'h66:   d = 8'h0C;
            8'h6E:   d = 8'h0A;
            8'h72:   d = 8'h0D;
            8'h74:   d = 8'h09;
            8'h76:   d = 8'h0B;
            8'h30:   d = 8'h00;
            default: d = ch;
        endcase
        return d;
    endfunction

    function automatic logic keeps_backslash(input logic [7:0] d);
        return !(d <= CTRL_MAX || d == CH_BACKSLASH || d == CH_QUOTE
                 || d == CH_DQUOTE || d == CH_BACKTICK || d == CH_SLASH
                 || d == CH_EQUALS);
    endfunction

endpackage
`default_nettype wire

// File: sv/bsd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_decode
// Combinational decode of one registered input byte against the current
// escape mode: up to two results and the next mode and high nibble.
// ----------------------------------------------------------------------------
module bsd_decode
    import bsd_pkg::*;
(
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_input,
    input  wire logic [1:0]  mode,
    input  wire logic [3:0]  nibble,
    output bsd_decode_t      dec
);

    always_comb
    begin
        logic [7:0] d;
        logic [7:0] hv;
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       err0;
        logic       err1;
        logic [1:0] mode_n;
        logic [3:0] nib_n;

        d      = simple_escape(in_byte);
        hv     = hex_value(in_byte);
        n      = 2'd0;
        b0     = 8'd0;
        b1     = 8'd0;
        err0   = 1'b0;
        err1   = 1'b0;
        mode_n = mode;
        nib_n  = nibble;

        unique case (mode)
            MODE_PLAIN:
            begin
                if (in_byte == CH_BACKSLASH) begin
                    mode_n = MODE_ESC;
                end else begin
                    b0 = in_byte;
                    n  = 2'd1;
                end
            end
            MODE_ESC:
            begin
                if (in_byte == CH_X) begin
                    mode_n = MODE_HEX_HI;
                end else if (in_byte == CH_N_UPPER) begin
                    mode_n = MODE_PLAIN;
                end else begin
                    if (keeps_backslash(d)) begin
                        b0 = CH_BACKSLASH;
                        b1 = d;
                        n  = 2'd2;
                    end else begin
                        b0 = d;
                        n  = 2'd1;
                    end
                    mode_n = MODE_PLAIN;
                end
            end
            MODE_HEX_HI:
            begin
                nib_n  = hv[3:0];
                mode_n = MODE_HEX_LO;
            end
            default:
            begin
                b0     = {nibble, 4'd0} + hv;
                n      = 2'd1;
                mode_n = MODE_PLAIN;
            end
        endcase

        // A text that ends inside an escape adds one error result. Only
        // silent paths leave the mode outside plain, so it is always first.
        if (end_of_input) begin
            if (mode_n != MODE_PLAIN) begin
                b0   = 8'd0;
                err0 = 1'b1;
                n    = 2'd1;
            end
            mode_n = MODE_PLAIN;
            nib_n  = 4'd0;
        end

        dec.count            = n;
        dec.res0.out_byte    = b0;
        dec.res0.is_error    = err0;
        dec.res0.run_last    = (n == 2'd1);
        dec.res0.stream_end  = end_of_input;
        dec.res1.out_byte    = b1;
        dec.res1.is_error    = err1;
        dec.res1.run_last    = 1'b1;
        dec.res1.stream_end  = end_of_input;
        dec.mode_next        = mode_n;
        dec.nibble_next      = nib_n;
    end

endmodule
`default_nettype wire

// File: sv/backslash_escape_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Streaming C-style backslash escape decoder, one text byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready, in_byte, end_of_input) takes one
//   raw text byte per transfer; end_of_input marks the last byte of a text.
//   The output channel (out_valid/out_ready, out_byte, is_error, run_last,
//   stream_end) gives zero, one or two results per input byte; run_last
//   flags the last result caused by a byte.
//   Path: an accepted byte is held in the input register, decoded from it
//   combinationally, and its first result goes to the output register.
//   Throughput: one input byte per cycle unless the output stalls. The
//   output register presents one result per cycle, so a byte that yields
//   two results (a kept backslash and its decoded byte) holds the second
//   in a side slot, and the input register stalls until that one moves on.
//   When the receiver stalls, the output register and the side slot keep
//   their contents, the input register fills, and in_ready drops; nothing is
//   lost. A new byte is taken while a result still waits on the output.
//   Reset (rst_n low, asynchronous) empties all stages and returns the
//   escape mode to plain pass-through with a zero high nibble.
// ----------------------------------------------------------------------------
module backslash_escape_decoder
    import bsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_input,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            is_error,
    output logic            run_last,
    output logic            stream_end
);

    // Input register stage.
    logic        a_valid_reg, a_valid_next;
    logic [7:0]  a_byte_reg;
    logic        a_end_reg;

    // Escape state.
    logic [1:0]  mode_reg, mode_next;
    logic [3:0]  nibble_reg, nibble_next;

    // Output register and the side slot for a second result.
    logic        out_valid_reg, out_valid_next;
    bsd_result_t out_res_reg, out_res_next;
    logic        hold_valid_reg, hold_valid_next;
    bsd_result_t hold_res_reg, hold_res_next;

    bsd_decode_t dec;
    logic        out_free;
    logic        a_fire;
    logic        in_fire;

    bsd_decode u_decode (
        .in_byte      (a_byte_reg),
        .end_of_input (a_end_reg),
        .mode         (mode_reg),
        .nibble       (nibble_reg),
        .dec          (dec)
    );

    // The output register can take a new result when it is empty or its
    // current result is transferred in this cycle.
    assign out_free = !out_valid_reg || out_ready;
    // The side slot has priority over the input register.
    assign a_fire   = a_valid_reg && !hold_valid_reg && out_free;
    assign in_ready = !a_valid_reg || a_fire;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        a_valid_next    = a_valid_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        hold_valid_next = hold_valid_reg;
        hold_res_next   = hold_res_reg;
        mode_next       = mode_reg;
        nibble_next     = nibble_reg;

        if (a_fire) begin
            a_valid_next = 1'b0;
        end
        if (in_fire) begin
            a_valid_next = 1'b1;
        end

        if (out_free) begin
            if (hold_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = hold_res_reg;
                hold_valid_next = 1'b0;
            end else if (a_fire) begin
                out_valid_next  = (dec.count != 2'd0);
                out_res_next    = dec.res0;
                hold_valid_next = (dec.count == 2'd2);
                hold_res_next   = dec.res1;
            end else begin
                out_valid_next  = 1'b0;
            end
        end

        if (a_fire) begin
            mode_next   = dec.mode_next;
            nibble_next = dec.nibble_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            mode_reg       <= MODE_PLAIN;
            nibble_reg     <= 4'd0;
        end else begin
            a_valid_reg    <= a_valid_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
            mode_reg       <= mode_next;
            nibble_reg     <= nibble_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            a_byte_reg <= in_byte;
            a_end_reg  <= end_of_input;
        end
        out_res_reg  <= out_res_next;
        hold_res_reg <= hold_res_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_res_reg.out_byte;
    assign is_error   = out_res_reg.is_error;
    assign run_last   = out_res_reg.run_last;
    assign stream_end = out_res_reg.stream_end;

    // The side slot is only filled together with the output register.
    a_hold_implies_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg
    ) else $error("side slot holds a result while the output is empty");

    // The input register never advances while a second result waits.
    a_no_fire_on_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> !a_fire
    ) else $error("input advanced past a pending second result");

    // Once the first of two results is taken, the second follows at once.
    a_hold_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && out_ready) |=> (out_valid_reg && !hold_valid_reg)
    ) else $error("pending second result was not presented");

    // An error result is always the last one of its byte and ends the text.
    a_error_shape: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.is_error)
            |-> (out_res_reg.run_last && out_res_reg.stream_end
                 && out_res_reg.out_byte == 8'd0)
    ) else $error("malformed error result");

endmodule
`default_nettype wire

// File: dv/backslash_escape_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// backslash_escape_decoder_tb
// Self-checking bench for the streaming backslash escape decoder. A short
// directed table covers pass-through extremes, simple, hex and silent escapes
// and texts that end inside an escape. Random well-formed escapes with random
// content then follow, mixed with stray bytes and early text ends. Every
// result transfer is checked field by field against an in-bench decoder model.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_tb;
    import bsd_pkg::*;

    // One line of the directed table. When hand_checked is set, the results
    // of the row are typed in below (count in n_results, at most one here).
    // Otherwise the in-bench model supplies them.
    typedef struct packed {
        logic [7:0]  text_byte;
        logic        last_of_text;
        logic        hand_checked;
        logic [1:0]  n_results;
        bsd_result_t result;
    } text_row_t;

    localparam int N_DIRECTED = 23;
    localparam int N_RANDOM   = 1600;
    localparam int IDLE_PCT   = 38;

    localparam text_row_t DIRECTED [N_DIRECTED] = '{
        // Plain bytes pass straight through, extremes of the byte range.
        '{"A",          1'b0, 1'b1, 2'd1, '{8'h41, 1'b0, 1'b1, 1'b0}},
        '{8'h00,        1'b0, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1, 1'b0}},
        '{8'hFF,        1'b1, 1'b1, 2'd1, '{8'hFF, 1'b0, 1'b1, 1'b1}},
        // A simple letter escape turns into a control code with no backslash.
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{"n",          1'b0, 1'b0, 2'd0, '0},
        // An unknown letter keeps its backslash: two results from one byte.
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{"q",          1'b0, 1'b0, 2'd0, '0},
        // A valid hex escape.
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{CH_X,         1'b0, 1'b0, 2'd0, '0},
        '{"4",          1'b0, 1'b0, 2'd0, '0},
        '{"1",          1'b0, 1'b0, 2'd0, '0},
        // Both hex digits invalid: each one counts as all ones.
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{CH_X,         1'b0, 1'b0, 2'd0, '0},
        '{"z",          1'b0, 1'b0, 2'd0, '0},
        '{"z",          1'b0, 1'b0, 2'd0, '0},
        // The silent escape gives nothing at all.
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{CH_N_UPPER,   1'b0, 1'b0, 2'd0, '0},
        // Text that ends right after a backslash.
        '{CH_BACKSLASH, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1, 1'b1}},
        // Text that ends while waiting for the high hex digit.
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{CH_X,         1'b1, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1, 1'b1}},
        // Text that ends while waiting for the low hex digit.
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, '0},
        '{CH_X,         1'b0, 1'b0, 2'd0, '0},
        '{"A",          1'b1, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1, 1'b1}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_input = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       is_error;
    logic       run_last;
    logic       stream_end;

    // Decoder state as the bench sees it, plus the results it still owes.
    logic [1:0]  model_mode = MODE_PLAIN;
    logic [3:0]  model_high = 4'h0;
    bsd_result_t decoded_due [$];

    int fail_count = 0;
    // While set, neither side idles, so the block runs at full rate.
    bit calm = 1'b0;

    backslash_escape_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_error     (is_error),
        .run_last     (run_last),
        .stream_end   (stream_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Value of a hex digit; anything that is not a digit counts as all ones.
    function automatic logic [7:0] digit_value(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
        begin
            return ch - "0";
        end
        if (ch >= "A" && ch <= "F")
        begin
            return ch - "A" + 8'd10;
        end
        if (ch >= "a" && ch <= "f")
        begin
            return ch - "a" + 8'd10;
        end
        return 8'hFF;
    endfunction

    // Appends one result to the list of results still owed.
    function automatic void owe_result(input bsd_result_t r);
        decoded_due = {decoded_due, r};
    endfunction

    // Decodes one text byte against the bench's copy of the decoder state.
    // When record is set, the results it yields are queued as owed.
    function automatic void unescape_byte(input logic [7:0] ch, input logic last,
                                          input bit record);
        bsd_result_t outs [2];
        int          n;
        logic [7:0]  code;
        logic [7:0]  digit;
        n = 0;
        case (model_mode)
            MODE_PLAIN:
            begin
                if (ch == CH_BACKSLASH)
                begin
                    model_mode = MODE_ESC;
                end
                else
                begin
                    outs[n] = '{ch, 1'b0, 1'b0, last};
                    n++;
                end
            end
            MODE_ESC:
            begin
                if (ch == CH_X)
                begin
                    model_mode = MODE_HEX_HI;
                end
                else if (ch == CH_N_UPPER)
                begin
                    model_mode = MODE_PLAIN;
                end
                else
                begin
                    case (ch)
                        "a":     code = 8'h07;
                        "b":     code = 8'h08;
                        "e":     code = 8'h1B;
                        "f":     code = 8'h0C;
                        "n":     code = 8'h0A;
                        "r":     code = 8'h0D;
                        "t":     code = 8'h09;
                        "v":     code = 8'h0B;
                        "0":     code = 8'h00;
                        default: code = ch;
                    endcase
                    // Quotes, slashes, the backslash itself, the equals sign
                    // and control codes lose the backslash; the rest keep it.
                    if (code > CTRL_MAX && code != CH_BACKSLASH && code != CH_QUOTE
                        && code != CH_DQUOTE && code != CH_BACKTICK
                        && code != CH_SLASH && code != CH_EQUALS)
                    begin
                        outs[n] = '{CH_BACKSLASH, 1'b0, 1'b0, last};
                        n++;
                    end
                    outs[n] = '{code, 1'b0, 1'b0, last};
                    n++;
                    model_mode = MODE_PLAIN;
                end
            end
            MODE_HEX_HI:
            begin
                digit      = digit_value(ch);
                model_high = digit[3:0];
                model_mode = MODE_HEX_LO;
            end
            default:
            begin
                // The sum wraps at eight bits.
                outs[n] = '{{model_high, 4'h0} + digit_value(ch), 1'b0, 1'b0, last};
                n++;
                model_mode = MODE_PLAIN;
            end
        endcase
        if (last)
        begin
            if (model_mode != MODE_PLAIN)
            begin
                outs[n] = '{8'h00, 1'b1, 1'b0, 1'b1};
                n++;
            end
            model_mode = MODE_PLAIN;
            model_high = 4'h0;
        end
        if (n > 0)
        begin
            outs[n - 1].run_last = 1'b1;
        end
        if (record)
        begin
            for (int i = 0; i < n; i++)
            begin
                owe_result(outs[i]);
            end
        end
    endfunction

    // Offers one byte on the input channel and returns once it has been
    // accepted. Random idle cycles come first unless the bench is calm.
    task automatic send_text_byte(input logic [7:0] ch, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= ch;
        end_of_input <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // Random byte with a random end mark; early ends cut escapes short.
    task automatic send_random_byte(input logic [7:0] ch, inout int sent);
        logic last;
        last = ($urandom_range(29) == 0);
        send_text_byte(ch, last);
        unescape_byte(ch, last, 1'b1);
        sent++;
    endtask

    // Mostly a valid hex digit of either case, sometimes any byte at all.
    function automatic logic [7:0] random_hex_char();
        int k;
        if ($urandom_range(99) < 15)
        begin
            return 8'($urandom_range(255));
        end
        k = $urandom_range(21);
        if (k < 10)
        begin
            return 8'("0" + k);
        end
        if (k < 16)
        begin
            return 8'("a" + k - 10);
        end
        return 8'("A" + k - 16);
    endfunction

    // Output side: random stalls on out_ready, and every result transfer is
    // compared with the oldest result still owed. Values are sampled at the
    // rising edge, before anything driven at that edge takes effect.
    always @(posedge clk)
    begin
        bsd_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_due.size() == 0)
                begin
                    $display("%0t: result with none owed: out_byte %02h is_error %0b",
                             $time, out_byte, is_error);
                    fail_count++;
                end
                else
                begin
                    want = decoded_due.pop_front();
                    if (out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.out_byte, out_byte);
                        fail_count++;
                    end
                    if (is_error !== want.is_error)
                    begin
                        $display("%0t: is_error expected %0b actual %0b",
                                 $time, want.is_error, is_error);
                        fail_count++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, want.run_last, run_last);
                        fail_count++;
                    end
                    if (stream_end !== want.stream_end)
                    begin
                        $display("%0t: stream_end expected %0b actual %0b",
                                 $time, want.stream_end, stream_end);
                        fail_count++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stimulus: reset, the directed table, then the random text.
    initial
    begin
        int sent;
        int pick;
        sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_text_byte(DIRECTED[i].text_byte, DIRECTED[i].last_of_text);
            if (DIRECTED[i].hand_checked)
            begin
                // The model still tracks the state; the results come from the row.
                unescape_byte(DIRECTED[i].text_byte, DIRECTED[i].last_of_text, 1'b0);
                if (DIRECTED[i].n_results != 2'd0)
                begin
                    owe_result(DIRECTED[i].result);
                end
            end
            else
            begin
                unescape_byte(DIRECTED[i].text_byte, DIRECTED[i].last_of_text, 1'b1);
            end
        end

        // Most of the random text is escapes with random content; the rest
        // is stray bytes, which may themselves be backslashes.
        while (sent < N_RANDOM)
        begin
            calm = (sent >= 600 && sent < 900);
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                send_random_byte(8'($urandom_range(255)), sent);
            end
            else if (pick < 55)
            begin
                send_random_byte(CH_BACKSLASH, sent);
                case ($urandom_range(15))
                    0:  send_random_byte("a", sent);
                    1:  send_random_byte("b", sent);
                    2:  send_random_byte("e", sent);
                    3:  send_random_byte("f", sent);
                    4:  send_random_byte("n", sent);
                    5:  send_random_byte("r", sent);
                    6:  send_random_byte("t", sent);
                    7:  send_random_byte("v", sent);
                    8:  send_random_byte("0", sent);
                    9:  send_random_byte(CH_BACKSLASH, sent);
                    10: send_random_byte(CH_QUOTE, sent);
                    11: send_random_byte(CH_DQUOTE, sent);
                    12: send_random_byte(CH_BACKTICK, sent);
                    13: send_random_byte(CH_SLASH, sent);
                    14: send_random_byte(CH_EQUALS, sent);
                    default: send_random_byte(8'($urandom_range(255)), sent);
                endcase
            end
            else if (pick < 82)
            begin
                send_random_byte(CH_BACKSLASH, sent);
                send_random_byte(CH_X, sent);
                send_random_byte(random_hex_char(), sent);
                send_random_byte(random_hex_char(), sent);
            end
            else if (pick < 90)
            begin
                send_random_byte(CH_BACKSLASH, sent);
                send_random_byte(CH_N_UPPER, sent);
            end
            else
            begin
                // A broken escape: a backslash followed by random bytes.
                send_random_byte(CH_BACKSLASH, sent);
                repeat ($urandom_range(2)) send_random_byte(8'($urandom_range(255)), sent);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain the owed results, then keep the clock running so that any
        // stray result the block still holds would show up.
        while (decoded_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("backslash_escape_decoder_tb: PASS");
        end
        else
        begin
            $display("backslash_escape_decoder_tb: FAIL");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("backslash_escape_decoder_tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/bsd_pkg.sv
sv/bsd_decode.sv
sv/backslash_escape_decoder.sv
dv/backslash_escape_decoder_tb.sv
